// ===== design/utf8_to_latin1_stream_decoder_macros.svh =====
// Assertion macros shared by the decoder's checker.
`ifndef UTF8_TO_LATIN1_STREAM_DECODER_MACROS_SVH
`define UTF8_TO_LATIN1_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U2L_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define U2L_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/u2l_pkg.sv =====
// Types, constants and helpers shared by the UTF-8 to Latin-1 decoder.
`timescale 1ns / 1ps
package u2l_pkg;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CTRL_LIMIT = 8'd32;
	localparam logic [7:0] CONT_LO    = 8'd128;
	localparam logic [7:0] CONT_HI    = 8'd191;
	localparam logic [7:0] LEAD2_MAX  = 8'd223;
	localparam logic [2:0] LEAD2_TAG  = 3'b110;
	localparam logic [5:0] LATIN_TAG  = 6'b110000;
	localparam logic [1:0] CONT_TAG   = 2'b10;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       stopped;
		logic       string_end;
	} out_word_t;

	typedef struct packed {
		logic       lead_pending;
		logic [1:0] lead_low_bits;
		logic       skip_next;
		logic       halted;
	} state_t;

	// controls and commas are not safe in a CSV field
	function automatic logic [7:0] clean_char(input logic [7:0] c);
		if (c < CTRL_LIMIT || c == CHAR_COMMA) begin
			return CHAR_DOT;
		end
		return c;
	endfunction

endpackage

// ===== design/u2l_decode.sv =====
// Per-word decode: next state and optional result from current state and input word.
`timescale 1ns / 1ps
module u2l_decode import u2l_pkg::*; (
	input  state_t    st,
	input  in_word_t  word,
	output state_t    st_next,
	output logic      res_valid,
	output out_word_t res
);

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;

	logic [1:0] kind;
	logic [7:0] ch;
	logic [7:0] b;
	logic [7:0] v;

	assign b = word.in_byte;
	assign v = {st.lead_low_bits, b[5:0]};

	always_comb begin
		st_next = st;
		kind    = KIND_NONE;
		ch      = '0;
		if (st.halted) begin
			kind = KIND_NONE;
		end else if (st.skip_next) begin
			st_next.skip_next = 1'b0;
		end else if (st.lead_pending) begin
			st_next.lead_pending = 1'b0;
			if (b[7:6] != CONT_TAG) begin
				kind = KIND_STOP;
			end else begin
				st_next.lead_low_bits = '0;
				if (v == 8'd0) begin
					kind = KIND_STOP;
				end else begin
					kind = KIND_CHAR;
					ch   = clean_char(v);
				end
			end
		end else if (b < CTRL_LIMIT || b inside {[CONT_LO:CONT_HI]}) begin
			kind = KIND_CHAR;
			ch   = CHAR_DOT;
		end else if (b > LEAD2_MAX) begin
			kind = KIND_STOP;
		end else if (b[7:5] == LEAD2_TAG) begin
			if (word.is_last) begin
				kind = KIND_STOP;
			end else if (b[7:2] != LATIN_TAG) begin
				// lead outside Latin-1: one '.' now, drop its continuation
				kind              = KIND_CHAR;
				ch                = CHAR_DOT;
				st_next.skip_next = 1'b1;
			end else begin
				st_next.lead_pending  = 1'b1;
				st_next.lead_low_bits = b[1:0];
			end
		end else begin
			kind = KIND_CHAR;
			ch   = clean_char(b);
		end

		if (kind == KIND_STOP) begin
			st_next.halted = 1'b1;
		end
		if (word.is_last) begin
			st_next = '0;
		end
	end

	assign res_valid      = (kind != KIND_NONE);
	assign res.out_byte   = (kind == KIND_CHAR) ? ch : 8'd0;
	assign res.has_byte   = (kind == KIND_CHAR);
	assign res.stopped    = (kind == KIND_STOP);
	assign res.string_end = word.is_last;

endmodule

// ===== design/utf8_to_latin1_stream_decoder.sv =====
// UTF-8 to Latin-1 stream decoder top level. One byte word in per cycle, at
// most one Latin-1 result word out per input word. An accepted word is held in
// the input register s1, is decoded against the sequence state by a few
// compares, and its result lands in the output register, where the result word is
// presented and held for as long as the result side stalls.
// Sustained rate is one word per cycle; the only thing that slows it is stall
// on the result side once the output register is full, and words that give no
// result (pending leads, swallowed or dropped bytes) pass even then. Stopped
// strings drop input until the last-marked byte.
`timescale 1ns / 1ps
module utf8_to_latin1_stream_decoder import u2l_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_word_t  src_word,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_word_t dst_word
);

	logic      valid_s1;
	in_word_t  word_s1;
	state_t    st_q;
	state_t    st_next;
	logic      res_valid;
	out_word_t res;
	logic      dst_valid_q;
	out_word_t dst_word_q;
	logic      advance;
	logic      load_s1;

	u2l_decode u_decode (
		.st        (st_q),
		.word      (word_s1),
		.st_next   (st_next),
		.res_valid (res_valid),
		.res       (res)
	);

	// s1 moves on unless it has a result and the output register is held
	assign advance   = valid_s1 && (!res_valid || !dst_valid_q || !dst_stall);
	assign src_stall = valid_s1 && !advance;
	assign load_s1   = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= src_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			dst_word_q <= res;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_word  = dst_word_q;

endmodule

// ===== design/u2l_checker.sv =====
// Port-level checker for the decoder, bound to the top level.
`timescale 1ns / 1ps
`include "utf8_to_latin1_stream_decoder_macros.svh"
module u2l_checker import u2l_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      dst_valid,
	input logic      dst_stall,
	input out_word_t dst_word
);

	`U2L_ASSERT_NEXT(a_dst_hold, clk, arst_n, dst_valid && dst_stall, dst_valid && $stable(dst_word), "result word changed while stalled")
	`U2L_ASSERT_NOW(a_one_kind, clk, arst_n, dst_valid, dst_word.has_byte != dst_word.stopped, "result must be exactly one of character or stop")
	`U2L_ASSERT_NOW(a_stop_zero, clk, arst_n, dst_valid && dst_word.stopped, dst_word.out_byte == 8'd0, "stop word carries a nonzero byte")
	`U2L_ASSERT_NOW(a_clean_out, clk, arst_n, dst_valid && dst_word.has_byte, dst_word.out_byte >= CTRL_LIMIT && dst_word.out_byte != CHAR_COMMA, "control or comma leaked to output")

endmodule

bind utf8_to_latin1_stream_decoder u2l_checker u_u2l_checker (.*);
